### hdl/vptb_pkg.sv
// Shared types, codes and defaults for the virtual periodic timer bank.
// No dependencies; every other file of the block but vptb_ram imports this package.
`default_nettype none

package vptb_pkg;

	// defaults for the top-level parameters
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int BASE_RATE_HZ_DEF = 1024;

	// the channel field addresses at most this many channels
	localparam int ADDR_CHANNELS = 16;

	localparam logic [3:0]  GOOD_WRITE_SIZE = 4'd4;
	localparam logic [15:0] LOWEST_RATE     = 16'd2;
	localparam logic [3:0]  RESET_EXP       = 4'd1;

	// opcodes
	localparam logic [2:0] OP_OPEN  = 3'd0;
	localparam logic [2:0] OP_CLOSE = 3'd1;
	localparam logic [2:0] OP_RATE  = 3'd2;
	localparam logic [2:0] OP_START = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_RATE = 2'd1;
	localparam logic [1:0] ST_SIZE = 2'd2;

	// result kinds
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD,
		S_TICK,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] exp;
	} rate_res_t;

endpackage

`default_nettype wire

### hdl/vptb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the per-channel state of the timer bank.
`default_nettype none

module vptb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/vptb_rate_chk.sv
// Checks a set-rate transaction: write size, then power-of-two range, and
// derives the rate exponent. Depends on vptb_pkg.
`default_nettype none

module vptb_rate_chk import vptb_pkg::*; #(
	parameter int BASE_RATE_HZ = BASE_RATE_HZ_DEF
) (
	input  wire logic [15:0] rate_hz,
	input  wire logic [3:0]  write_size,
	output rate_res_t        res
);

	logic       pow2;
	logic       in_range;
	logic [3:0] e;

	always_comb begin
		pow2     = (rate_hz & (rate_hz - 16'd1)) == 16'd0;
		in_range = (rate_hz >= LOWEST_RATE) && (32'(rate_hz) <= BASE_RATE_HZ);
		// a single bit is set when the rate is valid: OR together its position
		e = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (rate_hz[i]) begin
				e = e | 4'(i);
			end
		end
		res.exp = e;
		if (write_size != GOOD_WRITE_SIZE) begin
			res.status = ST_SIZE;
		end else if (!in_range || !pow2) begin
			res.status = ST_RATE;
		end else begin
			res.status = ST_OK;
		end
	end

endmodule

`default_nettype wire

### hdl/virtual_periodic_timer_bank.sv
// Top level of the virtual periodic timer bank: sequencer, state RAM and
// output register. Depends on vptb_pkg, vptb_ram and vptb_rate_chk.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | in_valid/in_stall  | opcode, channel, rate_hz, write_size,
//          |                    | nonblocking
//  output  | out_valid/out_stall| kind, which_channel, status, last,
//          |                    | periodic_irq_enable
//
// A command is accepted in S_IDLE, which reads the channel entry; S_CMD then
// modifies it, writes it back and loads the acknowledgement when the output
// register is free. A tick sweeps the state RAM one channel a cycle while no
// earlier completion is held up: S_TICK does one read-modify-write per channel,
// then S_FLUSH sends the last one. Ignored opcodes and channels do not stall.
// After reset the per-entry valid bits are clear and an unwritten entry reads
// as closed at 2 Hz; there is no clearing pass. A stalled output holds the
// sweep only when a second completion needs the output register.
`default_nettype none

module virtual_periodic_timer_bank import vptb_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int BASE_RATE_HZ = BASE_RATE_HZ_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [3:0]  channel,
	input  wire logic [15:0] rate_hz,
	input  wire logic [3:0]  write_size,
	input  wire logic        nonblocking,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [3:0]       which_channel,
	output logic [1:0]       status,
	output logic             last,
	output logic             periodic_irq_enable
);

	localparam int NCH = (NUM_CHANNELS < ADDR_CHANNELS) ? NUM_CHANNELS : ADDR_CHANNELS;
	localparam int AW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CW  = $clog2(BASE_RATE_HZ + 1);
	localparam int OW  = $clog2(NCH + 1);
	localparam int EW  = CW + 6;

	state_t state_q, state_nxt;

	// latched command
	logic [2:0]    op_q;
	logic [AW-1:0] ch_q;
	logic          nb_q;
	rate_res_t     rr_q;
	rate_res_t     rr;

	logic [AW-1:0] idx_q;
	logic          pend_q;
	logic [AW-1:0] pend_ch_q;
	logic [OW-1:0] ot_q;
	logic [NCH-1:0] vld_q;
	logic          rvld_q;

	logic          out_valid_q;
	logic          kind_q;
	logic [3:0]    chn_q;
	logic [1:0]    status_q;
	logic          last_q;
	logic          irq_q;

	// RAM port
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	// read entry, with the reset value for entries never written
	logic [EW-1:0] ent;
	logic          e_open, e_wait;
	logic [3:0]    e_exp;
	logic [CW-1:0] e_cnt;

	logic          in_acc, is_tick, is_cmd, out_free;
	logic [CW-1:0] thr, t_cnt;
	logic          done;
	logic [OW-1:0] ot_nxt;
	logic [EW-1:0] cmd_ent;

	// controls
	logic          out_ld, ld_kind, ld_last;
	logic [3:0]    ld_ch;
	logic [1:0]    ld_status;
	logic          ot_ld, pend_set, pend_clr, idx_inc, idx_clr;

	vptb_ram #(.WIDTH(EW), .DEPTH(NCH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	vptb_rate_chk #(.BASE_RATE_HZ(BASE_RATE_HZ)) u_rate (
		.rate_hz    (rate_hz),
		.write_size (write_size),
		.res        (rr)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_tick  = (opcode == OP_TICK);
	assign is_cmd   = (opcode < OP_TICK) && (32'(channel) < NUM_CHANNELS);
	assign out_free = !out_valid_q || !out_stall;

	assign ent = rvld_q ? rdata : {1'b0, 1'b0, RESET_EXP, CW'(0)};
	assign {e_open, e_wait, e_exp, e_cnt} = ent;

	// tick update of the entry under the sweep
	always_comb begin
		thr   = CW'(BASE_RATE_HZ >> e_exp);
		t_cnt = (e_open && (e_cnt < CW'(BASE_RATE_HZ))) ? CW'(e_cnt + 1'b1) : e_cnt;
		done  = e_open && e_wait && (t_cnt >= thr);
	end

	// command update of the addressed entry
	always_comb begin
		cmd_ent = ent;
		ot_nxt  = ot_q;
		case (op_q)
			OP_OPEN: begin
				cmd_ent = {1'b1, 1'b0, RESET_EXP, CW'(0)};
				if (!e_open) begin
					ot_nxt = OW'(ot_q + 1'b1);
				end
			end
			OP_CLOSE: begin
				if (e_open) begin
					cmd_ent = {1'b0, 1'b0, e_exp, e_cnt};
					ot_nxt  = OW'(ot_q - 1'b1);
				end
			end
			OP_RATE: begin
				if (rr_q.status == ST_OK) begin
					cmd_ent = {e_open, e_wait, rr_q.exp, e_cnt};
				end
			end
			OP_START: begin
				if (e_open) begin
					cmd_ent = {e_open, !nb_q, e_exp, CW'(0)};
				end
			end
			default: begin
				cmd_ent = ent;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && is_tick) begin
					state_nxt = S_TICK;
				end else if (in_acc && is_cmd) begin
					state_nxt = S_CMD;
				end
			end
			S_CMD: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_TICK: begin
				if (!(done && pend_q && !out_free) && (idx_q == AW'(NCH - 1))) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!pend_q || out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		we        = 1'b0;
		waddr     = ch_q;
		wdata     = cmd_ent;
		re        = 1'b0;
		raddr     = is_tick ? AW'(0) : channel[AW-1:0];
		out_ld    = 1'b0;
		ld_kind   = KIND_ACK;
		ld_ch     = 4'(ch_q);
		ld_status = ST_OK;
		ld_last   = 1'b1;
		ot_ld     = 1'b0;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		idx_inc   = 1'b0;
		idx_clr   = 1'b0;
		case (state_q)
			S_IDLE: begin
				re      = in_acc && (is_tick || is_cmd);
				idx_clr = 1'b1;
			end
			S_CMD: begin
				if (out_free) begin
					we        = 1'b1;
					ot_ld     = 1'b1;
					out_ld    = 1'b1;
					ld_status = (op_q == OP_RATE) ? rr_q.status : ST_OK;
				end
			end
			S_TICK: begin
				waddr = idx_q;
				wdata = {e_open, e_wait && !done, e_exp, t_cnt};
				raddr = AW'(idx_q + 1'b1);
				// hold while an earlier completion cannot leave yet
				if (!(done && pend_q && !out_free)) begin
					we       = 1'b1;
					out_ld   = done && pend_q;
					ld_kind  = KIND_DONE;
					ld_ch    = 4'(pend_ch_q);
					ld_last  = 1'b0;
					pend_set = done;
					if (idx_q != AW'(NCH - 1)) begin
						re      = 1'b1;
						idx_inc = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				ld_kind = KIND_DONE;
				ld_ch   = 4'(pend_ch_q);
				if (pend_q && out_free) begin
					out_ld   = 1'b1;
					pend_clr = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			ot_q        <= '0;
			pend_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
			if (ot_ld) begin
				ot_q <= ot_nxt;
			end
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (pend_clr) begin
				pend_q <= 1'b0;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= AW'(idx_q + 1'b1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= opcode;
			ch_q <= channel[AW-1:0];
			nb_q <= nonblocking;
			rr_q <= rr;
		end
		if (pend_set) begin
			pend_ch_q <= idx_q;
		end
		if (out_ld) begin
			kind_q   <= ld_kind;
			chn_q    <= ld_ch;
			status_q <= ld_status;
			last_q   <= ld_last;
			irq_q    <= ot_ld ? (ot_nxt != '0) : (ot_q != '0);
		end
	end

	assign out_valid           = out_valid_q;
	assign kind                = kind_q;
	assign which_channel       = chn_q;
	assign status              = status_q;
	assign last                = last_q;
	assign periodic_irq_enable = irq_q;

endmodule

`default_nettype wire

### hdl/vptb_chk.sv
// Port-level checker for the virtual periodic timer bank, with its bind.
// Depends on vptb_pkg and on the top-level port list.
`default_nettype none

module vptb_chk import vptb_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  opcode,
	input wire logic [3:0]  channel,
	input wire logic [15:0] rate_hz,
	input wire logic [3:0]  write_size,
	input wire logic        nonblocking,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        kind,
	input wire logic [3:0]  which_channel,
	input wire logic [1:0]  status,
	input wire logic        last,
	input wire logic        periodic_irq_enable
);

	logic acc_work, acc_drop;

	assign acc_work = in_valid && !in_stall &&
		((opcode == OP_TICK) || ((opcode < OP_TICK) && (32'(channel) < NUM_CHANNELS)));
	assign acc_drop = in_valid && !in_stall && (opcode > OP_TICK);

	// a transaction that does work holds off the next one
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		acc_work |=> in_stall)
		else $error("input not stalled after a working transaction");

	// a dropped opcode leaves the input open
	a_drop_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		acc_drop |=> !in_stall)
		else $error("input stalled after a dropped transaction");

	// acknowledgements end their transaction; completions carry no error
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_ACK)) |-> last)
		else $error("acknowledgement without last");

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_DONE)) |-> (status == ST_OK))
		else $error("completion with error status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(which_channel) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind virtual_periodic_timer_bank vptb_chk #(.NUM_CHANNELS(NUM_CHANNELS)) u_vptb_chk (.*);

`default_nettype wire
